// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, held off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BTQ_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define BTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BTQ_ASSERT(label, clk, rst_n, expr)
`define BTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/btq_pkg.sv =====
// ----------------------------------------------------------------------------
// btq_pkg
// shared types and constants of the branch tag queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TAG_BITS_DEF    = 6;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_SQUASH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic pop;
    logic load;
    logic occ;
  } cell_ctrl_t;

  typedef struct packed {
    logic kill;
    logic first;
  } cell_stat_t;

endpackage

// ===== sv/btq_cell.sv =====
// ----------------------------------------------------------------------------
// btq_cell
// one queue slot: holds a tag, shifts toward the head on pop, takes part in
// the squash match chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btq_cell
  import btq_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [TAG_BITS-1:0] cmd_tag,
  input  logic [TAG_BITS-1:0] nbr_tag,
  input  logic                kill_in,
  output logic [TAG_BITS-1:0] tag_o,
  output cell_stat_t          stat
);

  logic [TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0] tag_nxt;
  logic                match;

  assign match      = ctrl.occ && (tag_r == cmd_tag);
  assign stat.kill  = kill_in || match;
  assign stat.first = match && !kill_in;
  assign tag_o      = tag_r;

  always_comb begin
    priority if (ctrl.pop) begin
      tag_nxt = nbr_tag;
    end else if (ctrl.load) begin
      tag_nxt = cmd_tag;
    end else begin
      tag_nxt = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

// ===== sv/branch_tag_queue_with_squash.sv =====
// ----------------------------------------------------------------------------
// branch_tag_queue_with_squash
// ordered queue of in-flight branch tags with push, pop and squash
// ----------------------------------------------------------------------------
// One command (push, pop or squash) is taken in every clock cycle; busy is
// always low. The result appears one cycle after the transfer, strobed by
// out_valid for exactly one cycle, and must be taken then since the receiver
// cannot hold it off. Tags sit oldest first in a row of QUEUE_DEPTH cells;
// pop shifts the row toward the head, and squash ripples a match along the
// row, which sets the length of the longest path.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module branch_tag_queue_with_squash
  import btq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_func,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [3:0]          out_removed,
  output logic [3:0]          out_occupancy,
  output logic                out_full_flag,
  output logic                out_empty_flag
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  status_t             status_r;
  logic [3:0]          removed_r;
  logic [3:0]          occ_r;
  logic                full_r;
  logic                empty_r;

  logic                acc;
  func_t               cmd;
  logic                is_full;
  logic                is_empty;
  logic                push_ok;
  logic                pop_ok;
  logic                found;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    removed;
  status_t             status;

  cell_ctrl_t          ctrl     [QUEUE_DEPTH];
  cell_stat_t          stat     [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] kill;
  logic [QUEUE_DEPTH-1:0] first_vec;

  assign busy     = 1'b0;
  assign acc      = start && !busy;
  assign cmd      = func_t'(in_func);
  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign push_ok  = acc && (cmd == FUNC_PUSH) && !is_full;
  assign pop_ok   = acc && (cmd == FUNC_POP) && !is_empty;
  assign kill[0]  = 1'b0;
  assign found    = kill[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TAG_BITS-1:0] nbr;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = cell_tag[i];
    end else begin : g_mid
      assign nbr = cell_tag[i+1];
    end

    assign ctrl[i].pop  = pop_ok;
    assign ctrl[i].load = push_ok && (count_r == CNT_W'(i));
    assign ctrl[i].occ  = (CNT_W'(i) < count_r);

    btq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .cmd_tag (in_tag),
      .nbr_tag (nbr),
      .kill_in (kill[i]),
      .tag_o   (cell_tag[i]),
      .stat    (stat[i])
    );

    assign kill[i+1]    = stat[i].kill;
    assign first_vec[i] = stat[i].first;
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pos = pos | (first_vec[i] ? CNT_W'(i) : '0);
    end
  end

  always_comb begin
    count_nxt = count_r;
    removed   = '0;
    status    = ST_DONE;
    unique case (cmd)
      FUNC_PUSH: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_POP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          removed   = CNT_W'(1);
        end
      end
      FUNC_SQUASH: begin
        if (!found) begin
          status = ST_ABSENT;
        end else begin
          count_nxt = pos;
          removed   = count_r - pos;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
      if (acc) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status;
      removed_r <= 4'(removed);
      occ_r     <= 4'(count_nxt);
      full_r    <= (count_nxt == CNT_W'(QUEUE_DEPTH));
      empty_r   <= (count_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_removed    = removed_r;
  assign out_occupancy  = occ_r;
  assign out_full_flag  = full_r;
  assign out_empty_flag = empty_r;

  `BTQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH))
  `BTQ_ASSERT(a_first_onehot, clk, rst_n, $onehot0(first_vec))
  `BTQ_ASSERT_NEXT(a_pop_count, clk, rst_n, pop_ok, count_r == $past(count_r) - CNT_W'(1))
  `BTQ_ASSERT_NEXT(a_squash_shrinks, clk, rst_n, acc && (cmd == FUNC_SQUASH), count_r <= $past(count_r))
  `BTQ_ASSERT(a_flags_excl, clk, rst_n, !(out_valid_r && full_r && empty_r))

endmodule

// ===== bench/branch_tag_queue_with_squash_test.sv =====
// ----------------------------------------------------------------------------
// branch_tag_queue_with_squash_test
// self-checking bench for the branch tag queue with push, pop and squash
// ----------------------------------------------------------------------------
// A short table of directed commands covers the corner cases. It takes in the
// empty and full queue, a refused push, an ignored pop, a missing squash tag,
// a squash that hits the head, duplicate tags and the no-op function code.
// Random commands follow in phases that lean towards filling, draining or
// balance. Most squashes name a tag that is held in the queue. Every transfer
// is run through a queue model kept here, and each strobed result is compared
// field by field with the oldest expectation.
`timescale 1ns / 1ps

module branch_tag_queue_with_squash_test;
  import btq_pkg::*;

  localparam int DEPTH     = QUEUE_DEPTH_DEF;
  localparam int TAG_W     = TAG_BITS_DEF;
  localparam int N_RANDOM  = 1750;
  localparam int N_CALM    = 250;
  localparam int MAX_CYCLE = 200000;

  typedef struct {
    status_t    status;
    logic [3:0] removed;
    logic [3:0] occupancy;
    logic       full_flag;
    logic       empty_flag;
  } btq_result_t;

  typedef struct {
    func_t       func;
    logic [5:0]  tag;
    bit          pinned;
    btq_result_t res;
  } cmd_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_func;
  logic [TAG_W-1:0] in_tag;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [3:0]       out_removed;
  logic [3:0]       out_occupancy;
  logic             out_full_flag;
  logic             out_empty_flag;

  logic [TAG_W-1:0] model_tags [DEPTH];
  int               model_head;
  int               model_tail;
  int               model_count;

  btq_result_t      pending_results [$];
  cmd_row_t         cmd_table [$];
  btq_result_t      want;
  int               n_err;
  int               n_results;
  int               n_cycles;
  int               n_status [4];
  int               n_full_seen;
  int               n_squash_hits;

  branch_tag_queue_with_squash #(
    .QUEUE_DEPTH    (DEPTH),
    .TAG_BITS       (TAG_W)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_removed    (out_removed),
    .out_occupancy  (out_occupancy),
    .out_full_flag  (out_full_flag),
    .out_empty_flag (out_empty_flag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // queue model, advanced once per accepted transfer
  task automatic advance_tag_model(input func_t f, input logic [TAG_W-1:0] t,
                                   output btq_result_t r);
    int  pos;
    bit  hit;
    r.status  = ST_DONE;
    r.removed = 4'd0;
    hit       = 1'b0;
    case (f)
      FUNC_PUSH: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_tags[model_tail] = t;
          model_tail             = (model_tail + 1) % DEPTH;
          model_count++;
        end
      end
      FUNC_POP: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_head = (model_head + 1) % DEPTH;
          model_count--;
          r.removed  = 4'd1;
        end
      end
      FUNC_SQUASH: begin
        for (pos = 0; pos < model_count && !hit; pos++) begin
          if (model_tags[(model_head + pos) % DEPTH] == t) begin
            hit = 1'b1;
            break;
          end
        end
        if (!hit) begin
          r.status = ST_ABSENT;
        end else begin
          r.removed   = 4'(model_count - pos);
          model_count = pos;
          model_tail  = (model_head + pos) % DEPTH;
        end
      end
      default: begin
      end
    endcase
    r.occupancy  = 4'(model_count);
    r.full_flag  = (model_count == DEPTH);
    r.empty_flag = (model_count == 0);
  endtask

  task automatic add_row(input func_t f, input logic [5:0] t, input bit pin,
                         input status_t st, input int rem, input int occ);
    cmd_row_t row;
    row.func           = f;
    row.tag            = t;
    row.pinned         = pin;
    row.res.status     = st;
    row.res.removed    = 4'(rem);
    row.res.occupancy  = 4'(occ);
    row.res.full_flag  = (occ == DEPTH);
    row.res.empty_flag = (occ == 0);
    cmd_table.push_back(row);
  endtask

  // one command transfer; start stays high on return
  task automatic send_cmd(input func_t f, input logic [TAG_W-1:0] t, input bit pin,
                          input btq_result_t typed);
    btq_result_t r;
    in_func <= f;
    in_tag  <= t;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    advance_tag_model(f, t, r);
    pending_results.push_back(pin ? typed : r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_error(input string what, input btq_result_t w);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch (%s): status %0d/%0d removed %0d/%0d occ %0d/%0d full %0b/%0b empty %0b/%0b",
               what, w.status, out_status, w.removed, out_removed, w.occupancy,
               out_occupancy, w.full_flag, out_full_flag, w.empty_flag, out_empty_flag);
    end
  endtask

  // result check, expected/actual in each field
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      n_status[out_status]++;
      if (out_full_flag === 1'b1) n_full_seen++;
      if (out_status == ST_DONE && out_removed > 4'd1) n_squash_hits++;
      if (pending_results.size() == 0) begin
        want = '{ST_DONE, 4'd0, 4'd0, 1'b0, 1'b0};
        note_error("unexpected transfer", want);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_removed !== want.removed ||
            out_occupancy !== want.occupancy || out_full_flag !== want.full_flag ||
            out_empty_flag !== want.empty_flag) begin
          note_error("field", want);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= MAX_CYCLE) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    btq_result_t none;
    int          n;
    int          k;
    int          mode;
    int          pick;
    func_t       f;
    logic [5:0]  t;

    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = FUNC_NOP;
    in_tag      = '0;
    n_err       = 0;
    n_results   = 0;
    n_cycles    = 0;
    n_full_seen = 0;
    n_squash_hits = 0;
    n_status    = '{0, 0, 0, 0};
    model_head  = 0;
    model_tail  = 0;
    model_count = 0;
    none        = '{ST_DONE, 4'd0, 4'd0, 1'b0, 1'b0};

    // directed table
    add_row(FUNC_POP,    6'd0,  1, ST_EMPTY,  0, 0);
    add_row(FUNC_SQUASH, 6'd0,  1, ST_ABSENT, 0, 0);
    add_row(FUNC_NOP,    6'd63, 1, ST_DONE,   0, 0);
    add_row(FUNC_PUSH,   6'd0,  1, ST_DONE,   0, 1);
    add_row(FUNC_PUSH,   6'd63, 1, ST_DONE,   0, 2);
    for (k = 1; k <= 6; k++) add_row(FUNC_PUSH, 6'(k), 1, ST_DONE, 0, k + 2);
    add_row(FUNC_PUSH,   6'd7,  1, ST_FULL,   0, 8);
    add_row(FUNC_SQUASH, 6'd42, 1, ST_ABSENT, 0, 8);
    add_row(FUNC_SQUASH, 6'd4,  0, ST_DONE,   0, 0);
    add_row(FUNC_POP,    6'd0,  0, ST_DONE,   0, 0);
    add_row(FUNC_SQUASH, 6'd63, 0, ST_DONE,   0, 0);
    add_row(FUNC_PUSH,   6'd9,  0, ST_DONE,   0, 0);
    add_row(FUNC_PUSH,   6'd9,  0, ST_DONE,   0, 0);
    add_row(FUNC_PUSH,   6'd17, 0, ST_DONE,   0, 0);
    add_row(FUNC_SQUASH, 6'd9,  0, ST_DONE,   0, 0);
    add_row(FUNC_POP,    6'd0,  0, ST_DONE,   0, 0);
    add_row(FUNC_PUSH,   6'd21, 0, ST_DONE,   0, 0);
    add_row(FUNC_SQUASH, 6'd21, 0, ST_DONE,   0, 0);
    add_row(FUNC_NOP,    6'd0,  0, ST_DONE,   0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (cmd_table[i]) begin
      send_cmd(cmd_table[i].func, cmd_table[i].tag, cmd_table[i].pinned, cmd_table[i].res);
    end
    drain_results();

    // random phases: fill, drain, balanced
    mode = 0;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      case (mode)
        0:       f = (pick < 60) ? FUNC_PUSH : (pick < 72) ? FUNC_POP :
                     (pick < 97) ? FUNC_SQUASH : FUNC_NOP;
        1:       f = (pick < 30) ? FUNC_PUSH : (pick < 60) ? FUNC_POP :
                     (pick < 96) ? FUNC_SQUASH : FUNC_NOP;
        default: f = (pick < 45) ? FUNC_PUSH : (pick < 70) ? FUNC_POP :
                     (pick < 96) ? FUNC_SQUASH : FUNC_NOP;
      endcase
      if (f == FUNC_SQUASH && model_count > 0 && $urandom_range(0, 3) != 0) begin
        t = model_tags[(model_head + $urandom_range(0, model_count - 1)) % DEPTH];
      end else if ($urandom_range(0, 2) == 0) begin
        t = 6'($urandom_range(0, 3));
      end else begin
        t = 6'($urandom_range(0, 63));
      end
      send_cmd(f, t, 1'b0, none);
      if (n == N_RANDOM / 2) begin
        drain_results();
      end else if (n < N_RANDOM - N_CALM && mode != 2 && $urandom_range(0, 4) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d results checked: %0d done, %0d refused full, %0d empty, %0d tag absent",
             n_results, n_status[ST_DONE], n_status[ST_FULL], n_status[ST_EMPTY],
             n_status[ST_ABSENT]);
    $display("full queue seen %0d times, %0d multi-entry squashes, %0d mismatches",
             n_full_seen, n_squash_hits, n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/btq_pkg.sv
sv/btq_cell.sv
sv/branch_tag_queue_with_squash.sv
bench/branch_tag_queue_with_squash_test.sv
